// ===== sv/cdl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdl_pkg;

    // loop defaults
    localparam int TICK_SHIFT_DEF = 2;
    localparam int TIMER_BITS_DEF = 24;

    // widths of the serial units
    localparam int DIV_NUM_W = 80;
    localparam int USEC_W    = 20;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

    // register indexes
    typedef enum logic [2:0] {
        REG_ENABLE  = 3'd0,
        REG_THRESH  = 3'd1,
        REG_PREC    = 3'd2,
        REG_PHASE   = 3'd3,
        REG_FREQ    = 3'd4,
        REG_TRACK   = 3'd5,
        REG_COMP    = 3'd6,
        REG_FACTOR  = 3'd7
    } t_reg_idx;

    // result status codes
    localparam logic [2:0] ST_DISABLED = 3'd0;
    localparam logic [2:0] ST_SLEWED   = 3'd1;
    localparam logic [2:0] ST_STEP     = 3'd2;
    localparam logic [2:0] ST_TICK     = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    // register reset values
    localparam logic [46:0] THRESH_RST = 47'd549755814;
    localparam logic [12:0] PREC_RST   = 13'd1;
    localparam logic [4:0]  PHASE_RST  = 5'd8;
    localparam logic [4:0]  FREQ_RST   = 5'd10;
    localparam logic [4:0]  TRACK_RST  = 5'd8;
    localparam logic [4:0]  COMP_RST   = 5'd13;
    localparam logic [4:0]  FACTOR_RST = 5'd18;

endpackage

`default_nettype wire

// ===== sv/cdl_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cdl_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [47:0] offset;

    modport source (output valid, output op, output offset, input ready);
    modport sink   (input valid, input op, input offset, output ready);
endinterface

`default_nettype wire

// ===== sv/cdl_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cdl_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [47:0] step_amount;
    logic signed [20:0] slew_usec;

    modport source (output valid, output status, output step_amount, output slew_usec,
                    input ready);
    modport sink   (input valid, input status, input step_amount, input slew_usec,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/cdl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module cdl_div #(
    parameter int NW = cdl_pkg::DIV_NUM_W,
    parameter int DW = 88
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          take;

    assign trial = {r_r, r_q[NW-1]};
    assign take  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_r    <= '0;
                r_d    <= i_den;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_r   <= take ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
                r_q   <= {r_q[NW-2:0], take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule

`default_nettype wire

// ===== sv/clock_discipline_loop.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Clock discipline loop: an offset transaction either requests a step (offset beyond
// the threshold, loop restarts) or loads the phase error, corrects the drift by
// offset / (weight * elapsed seconds) and updates the compliance average; a tick
// transaction ages the timer, decays the phase error and emits the slew in whole
// microseconds, truncated to the precision and saturated at one second. All times
// are signed Q32 seconds. One item is handled at a time. An offset with a drift
// update runs a serial ai * elapsed multiply, then a bit-serial divide; a tick runs
// a serial multiply by one million, then two passes of the shared divider for the
// precision remainder and the Q32 back-conversion. A finished result sits in an
// output register while the next item is accepted.
module clock_discipline_loop #(
    parameter int TICK_SHIFT = cdl_pkg::TICK_SHIFT_DEF,
    parameter int TIMER_BITS = cdl_pkg::TIMER_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [46:0] i_cfg_data,
    cdl_in_if.sink           i_in,
    cdl_out_if.source        o_out
);
    localparam int PW = 64 + TIMER_BITS;                         // product / divisor
    localparam int MW = (TIMER_BITS > cdl_pkg::USEC_W) ? TIMER_BITS : cdl_pkg::USEC_W;
    localparam int CW = $clog2(MW + 1);
    localparam int EW = ((TIMER_BITS > TICK_SHIFT) ? TIMER_BITS : TICK_SHIFT + 1) + 1;
    localparam int NW = cdl_pkg::DIV_NUM_W;

    localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SMIN = {1'b1, {63{1'b0}}};

    // saturating helpers, all shifts of signed values truncate toward zero
    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
        if (neg) return m[63] ? SMIN : -$signed(m);
        return m[63] ? SMAX : $signed(m);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) return a[63] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] a,
                                                     input logic [4:0] sh);
        return from_mag(a[63], mag64(a) >> sh);
    endfunction

    typedef enum logic [4:0] {
        S_IDLE, S_O_CHK, S_O_AI, S_O_MUL, S_O_DIV, S_O_CMP1, S_O_CMP2,
        S_T_ELAP, S_T_PH, S_T_REM, S_T_MAG, S_T_MUL, S_T_SAT, S_T_PREC,
        S_T_BACK, S_FIN
    } t_state;

    // configuration
    logic        r_enable;
    logic [46:0] r_thresh;
    logic [12:0] r_prec;
    logic [4:0]  r_phase_sh, r_freq_sh, r_track_sh, r_comp_sh, r_factor_sh;

    // loop state
    logic signed [63:0]  r_drift, r_comp_avg, r_phase_err, r_slew_rem;
    logic [TIMER_BITS-1:0] r_elapsed;
    logic                r_first;

    // working registers
    t_state              r_state;
    logic signed [47:0]  r_off;
    logic signed [63:0]  r_adj;
    logic                r_neg;
    logic [63:0]         r_mcand;
    logic [MW-1:0]       r_mplr;
    logic [PW-1:0]       r_acc;
    logic [CW-1:0]       r_cnt;
    logic [20:0]         r_umag;
    logic                r_div_start;
    logic [NW-1:0]       r_div_num;
    logic [PW-1:0]       r_div_den;

    // result and output registers
    logic [2:0]          r_res_status;
    logic signed [47:0]  r_res_step;
    logic signed [20:0]  r_res_slew;
    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic signed [47:0]  r_out_step;
    logic signed [20:0]  r_out_slew;

    logic                div_done;
    logic [NW-1:0]       div_quo;
    logic [PW-1:0]       div_rem;

    cdl_div #(.NW(NW), .DW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // offset magnitude, the most negative offset comes out as 2^47
    logic [47:0]         off_mag;
    logic signed [63:0]  off64;
    assign off_mag = r_off[47] ? 48'(-r_off) : 48'(r_off);
    assign off64   = 64'(r_off);

    // drift weight: 2^comp - 2^factor * |compliance|, floored at 1.0
    logic [63:0] base, limit, wgt, cmag, ai;
    assign base  = 64'd1 << (6'(r_comp_sh) + 6'd32);
    assign limit = base >> r_factor_sh;
    assign cmag  = mag64(r_comp_avg);
    assign wgt   = base - (cmag << r_factor_sh);
    assign ai    = (cmag <= limit && wgt > 64'h1_0000_0000) ? wgt : 64'h1_0000_0000;

    // one shift-add step of the serial multiplier
    logic [PW-1:0] acc_step;
    assign acc_step = (r_acc << 1) + (r_mplr[MW-1] ? PW'(r_mcand) : '0);

    // timer aging
    logic [EW-1:0] el_sum;
    localparam logic [EW-1:0] TMAX = EW'({TIMER_BITS{1'b1}});
    assign el_sum = EW'(r_elapsed) + (EW'(1) << TICK_SHIFT);

    logic [63:0] adj_mag;
    logic [20:0] usat;
    assign adj_mag = mag64(r_adj);
    assign usat = (r_acc[52:32] > 21'(cdl_pkg::USEC_PER_SEC))
                  ? 21'(cdl_pkg::USEC_PER_SEC) : r_acc[52:32];

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_thresh    <= cdl_pkg::THRESH_RST;
            r_prec      <= cdl_pkg::PREC_RST;
            r_phase_sh  <= cdl_pkg::PHASE_RST;
            r_freq_sh   <= cdl_pkg::FREQ_RST;
            r_track_sh  <= cdl_pkg::TRACK_RST;
            r_comp_sh   <= cdl_pkg::COMP_RST;
            r_factor_sh <= cdl_pkg::FACTOR_RST;
            r_drift     <= '0;
            r_comp_avg  <= '0;
            r_phase_err <= '0;
            r_slew_rem  <= '0;
            r_elapsed   <= '0;
            r_first     <= 1'b1;
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_div_start <= 1'b0;

            if (i_cfg_we) begin
                unique case (cdl_pkg::t_reg_idx'(i_cfg_idx))
                    cdl_pkg::REG_ENABLE: r_enable    <= i_cfg_data[0];
                    cdl_pkg::REG_THRESH: r_thresh    <= i_cfg_data;
                    cdl_pkg::REG_PREC:   r_prec      <= i_cfg_data[12:0];
                    cdl_pkg::REG_PHASE:  r_phase_sh  <= i_cfg_data[4:0];
                    cdl_pkg::REG_FREQ:   r_freq_sh   <= i_cfg_data[4:0];
                    cdl_pkg::REG_TRACK:  r_track_sh  <= i_cfg_data[4:0];
                    cdl_pkg::REG_COMP:   r_comp_sh   <= i_cfg_data[4:0];
                    cdl_pkg::REG_FACTOR: r_factor_sh <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            // the finishing state reloads the output register itself
            if (o_out.ready && r_out_valid && r_state != S_FIN) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_off        <= i_in.offset;
                        r_res_status <= cdl_pkg::ST_DISABLED;
                        r_res_step   <= '0;
                        r_res_slew   <= '0;
                        if (!r_enable)    r_state <= S_FIN;
                        else if (i_in.op) r_state <= S_T_ELAP;
                        else              r_state <= S_O_CHK;
                    end
                end

                // offset transaction
                S_O_CHK: begin
                    r_slew_rem <= '0;
                    if (off_mag > {1'b0, r_thresh}) begin
                        r_first      <= 1'b1;
                        r_elapsed    <= '0;
                        r_phase_err  <= '0;
                        r_res_status <= cdl_pkg::ST_STEP;
                        r_res_step   <= r_off;
                        r_state      <= S_FIN;
                    end else begin
                        r_phase_err <= off64;
                        if (r_first) begin
                            r_first <= 1'b0;
                            r_state <= S_O_CMP1;
                        end else if (r_elapsed != '0) begin
                            r_state <= S_O_AI;
                        end else begin
                            r_state <= S_O_CMP1;
                        end
                    end
                end
                S_O_AI: begin
                    r_mcand <= ai;
                    r_mplr  <= MW'(r_elapsed) << (MW - TIMER_BITS);
                    r_acc   <= '0;
                    r_cnt   <= CW'(TIMER_BITS);
                    r_state <= S_O_MUL;
                end
                S_O_MUL: begin
                    // shift-add, one multiplier bit per cycle
                    r_acc  <= acc_step;
                    r_mplr <= r_mplr << 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_div_num   <= NW'({off_mag, 32'd0});
                        r_div_den   <= acc_step;
                        r_div_start <= 1'b1;
                        r_state     <= S_O_DIV;
                    end
                end
                S_O_DIV: begin
                    if (div_done) begin
                        r_drift <= sat_add(r_drift, from_mag(r_off[47], div_quo[63:0]));
                        r_state <= S_O_CMP1;
                    end
                end
                S_O_CMP1: begin
                    r_elapsed <= '0;
                    r_adj     <= shr_trunc(sat_sub(off64, r_comp_avg), r_track_sh);
                    r_state   <= S_O_CMP2;
                end
                S_O_CMP2: begin
                    r_comp_avg   <= sat_add(r_comp_avg, r_adj);
                    r_res_status <= cdl_pkg::ST_SLEWED;
                    r_state      <= S_FIN;
                end

                // tick transaction
                S_T_ELAP: begin
                    r_elapsed <= (el_sum > TMAX) ? {TIMER_BITS{1'b1}} : el_sum[TIMER_BITS-1:0];
                    r_adj     <= shr_trunc(r_phase_err, r_phase_sh);
                    r_state   <= S_T_PH;
                end
                S_T_PH: begin
                    r_phase_err <= r_phase_err - r_adj;
                    r_adj       <= sat_add(r_adj, shr_trunc(r_drift, r_freq_sh));
                    r_state     <= S_T_REM;
                end
                S_T_REM: begin
                    r_adj   <= sat_add(r_adj, r_slew_rem);
                    r_state <= S_T_MAG;
                end
                S_T_MAG: begin
                    r_neg <= r_adj[63];
                    if (adj_mag[63:33] != '0) begin
                        // well beyond one second, saturate
                        r_acc   <= PW'(cdl_pkg::USEC_PER_SEC) << 32;
                        r_state <= S_T_SAT;
                    end else begin
                        r_mcand <= 64'(adj_mag[32:0]);
                        r_mplr  <= MW'(cdl_pkg::USEC_PER_SEC) << (MW - cdl_pkg::USEC_W);
                        r_acc   <= '0;
                        r_cnt   <= CW'(cdl_pkg::USEC_W);
                        r_state <= S_T_MUL;
                    end
                end
                S_T_MUL: begin
                    r_acc  <= acc_step;
                    r_mplr <= r_mplr << 1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) r_state <= S_T_SAT;
                end
                S_T_SAT: begin
                    // truncate to the precision: u - (u mod prec)
                    r_umag      <= usat;
                    r_div_num   <= NW'(usat);
                    r_div_den   <= PW'((r_prec == '0) ? 13'd1 : r_prec);
                    r_div_start <= 1'b1;
                    r_state     <= S_T_PREC;
                end
                S_T_PREC: begin
                    if (div_done) begin
                        r_umag      <= r_umag - div_rem[20:0];
                        r_div_num   <= NW'({21'(r_umag - div_rem[20:0]), 32'd0});
                        r_div_den   <= PW'(cdl_pkg::USEC_PER_SEC);
                        r_div_start <= 1'b1;
                        r_state     <= S_T_BACK;
                    end
                end
                S_T_BACK: begin
                    if (div_done) begin
                        r_slew_rem <= sat_sub(r_adj, from_mag(r_neg, div_quo[63:0]));
                        if (r_umag == '0) begin
                            r_res_status <= cdl_pkg::ST_ZERO;
                        end else begin
                            r_res_status <= cdl_pkg::ST_TICK;
                            r_res_slew   <= r_neg ? -$signed(r_umag) : $signed(r_umag);
                        end
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    // hand the result over once the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_step   <= r_res_step;
                        r_out_slew   <= r_res_slew;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.step_amount = r_out_step;
    assign o_out.slew_usec   = r_out_slew;
endmodule

`default_nettype wire

// ===== bench/tb_clock_discipline_loop.sv =====
`timescale 1ns / 1ps

module tb_clock_discipline_loop;

    typedef struct packed {
        logic        op;
        logic [47:0] offset;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] step_amount;
        logic [20:0] slew_usec;
    } t_result;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic OP_OFFSET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [46:0] i_cfg_data;

    cdl_in_if  in_bus ();
    cdl_out_if out_bus ();

    clock_discipline_loop dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus.sink),
        .o_out      (out_bus.source)
    );

    // predictor copy of the registers
    logic        cfg_enable;
    logic [46:0] cfg_thresh;
    logic [12:0] cfg_prec;
    logic [4:0]  cfg_phase, cfg_freq, cfg_track, cfg_comp, cfg_factor;

    // predictor copy of the loop state
    longint      drift_q, comp_avg_q, phase_err_q, remainder_q;
    longint unsigned elapsed_q;
    bit          first_q;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      error_count;
    int      stall_in, stall_out;
    bit      idle_off;
    bit      done;
    bit      in_taken;
    int      quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // ---------------- predictor ----------------
    function automatic longint unsigned magnitude(input longint a);
        return a < 0 ? 64'd0 - longint'(a) : a;
    endfunction

    function automatic longint with_sign(input bit neg, input longint unsigned m);
        if (neg) return (m >= 64'h8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000 : -longint'(m);
        return (m > 64'h7fff_ffff_ffff_ffff) ? 64'sh7fff_ffff_ffff_ffff : longint'(m);
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic longint sub_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // right shift rounding toward zero
    function automatic longint shift_toward_zero(input longint a, input logic [4:0] s);
        return with_sign(a < 0, magnitude(a) >> s);
    endfunction

    function automatic t_result predict_loop(input t_item it);
        t_result r;
        longint off, adj, back;
        longint unsigned offmag, base, cm, ai, w, q, amag, umag, prec;
        logic [127:0] num, den, prod;
        bit neg;
        r = '0;
        off = longint'(signed'(it.offset));
        if (!cfg_enable) begin
            r.status = cdl_pkg::ST_DISABLED;
            return r;
        end
        if (it.op == OP_OFFSET) begin
            offmag = magnitude(off);
            remainder_q = 0;
            if (offmag > 64'(cfg_thresh)) begin
                // step request restarts the loop
                first_q = 1;
                elapsed_q = 0;
                phase_err_q = 0;
                r.status = cdl_pkg::ST_STEP;
                r.step_amount = it.offset;
                return r;
            end
            phase_err_q = off;
            if (first_q) begin
                first_q = 0;
            end else if (elapsed_q > 0) begin
                base = 64'd1 << (cfg_comp + 32);
                cm = magnitude(comp_avg_q);
                ai = 64'd1 << 32;
                if (cm <= (base >> cfg_factor)) begin
                    w = base - (cm << cfg_factor);
                    if (w > ai) ai = w;
                end
                num = 128'(offmag) << 32;
                den = 128'(ai) * 128'(elapsed_q);
                q = 64'(num / den);
                drift_q = add_sat(drift_q, with_sign(off < 0, q));
            end
            elapsed_q = 0;
            comp_avg_q = add_sat(comp_avg_q,
                shift_toward_zero(sub_sat(off, comp_avg_q), cfg_track));
            r.status = cdl_pkg::ST_SLEWED;
            return r;
        end
        // tick: timer saturates at its width
        elapsed_q = (elapsed_q > 64'hff_ffff - 4) ? 64'hff_ffff : elapsed_q + 4;
        adj = shift_toward_zero(phase_err_q, cfg_phase);
        phase_err_q -= adj;
        adj = add_sat(adj, shift_toward_zero(drift_q, cfg_freq));
        adj = add_sat(adj, remainder_q);
        neg = adj < 0;
        amag = magnitude(adj);
        prod = 128'(amag) * 128'd1000000;
        umag = prod[95:32];
        if (prod[127:96] != 0 || umag > 1000000) umag = 1000000;
        prec = (cfg_prec == 0) ? 1 : 64'(cfg_prec);
        umag = (umag / prec) * prec;
        back = with_sign(neg, (umag << 32) / 1000000);
        remainder_q = sub_sat(adj, back);
        if (umag == 0) begin
            r.status = cdl_pkg::ST_ZERO;
        end else begin
            r.status = cdl_pkg::ST_TICK;
            r.slew_usec = 21'(with_sign(neg, umag));
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    task automatic write_reg(input cdl_pkg::t_reg_idx idx, input logic [46:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            cdl_pkg::REG_ENABLE: cfg_enable = val[0];
            cdl_pkg::REG_THRESH: cfg_thresh = val;
            cdl_pkg::REG_PREC:   cfg_prec = val[12:0];
            cdl_pkg::REG_PHASE:  cfg_phase = val[4:0];
            cdl_pkg::REG_FREQ:   cfg_freq = val[4:0];
            cdl_pkg::REG_TRACK:  cfg_track = val[4:0];
            cdl_pkg::REG_COMP:   cfg_comp = val[4:0];
            cdl_pkg::REG_FACTOR: cfg_factor = val[4:0];
            default: ;
        endcase
    endtask

    // wait until the block has drained, plus the tick latency
    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    t_item cur_item;

    // input transactions are taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            expected_results.push_back(predict_loop(cur_item));
            void'(pending_items.pop_front());
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            // an offered transaction is held until it is taken
            in_taken = 1'b0;
            if (stall_in > 0) begin
                stall_in--;
                in_bus.valid <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 15) == 0) begin
                stall_in = $urandom_range(1, 10);
                in_bus.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                cur_item = pending_items[0];
                in_bus.valid <= 1'b1;
                in_bus.op <= cur_item.op;
                in_bus.offset <= cur_item.offset;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (stall_out > 0) begin
            stall_out--;
            out_bus.ready <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 15) == 0) begin
            stall_out = $urandom_range(1, 10);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                exp_r = expected_results.pop_front();
                if (out_bus.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d expected %0d",
                        out_bus.status, exp_r.status));
                if (out_bus.step_amount !== exp_r.step_amount)
                    report_mismatch($sformatf("step_amount %0d expected %0d",
                        out_bus.step_amount, signed'(exp_r.step_amount)));
                if (out_bus.slew_usec !== exp_r.slew_usec)
                    report_mismatch($sformatf("slew_usec %0d expected %0d",
                        out_bus.slew_usec, signed'(exp_r.slew_usec)));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [47:0] rand_offset(input logic [46:0] thr);
        logic [47:0] v;
        case ($urandom_range(0, 5))
            0: v = 48'({$urandom(), $urandom()});
            1: v = 48'(signed'({1'b0, thr}));
            2: v = 48'($urandom_range(0, 4000000));
            3: v = -48'($urandom_range(0, 400000000));
            default: v = 48'(longint'($urandom_range(0, 600000000)) - 300000000);
        endcase
        return v;
    endfunction

    task automatic push_item(input logic op, input logic [47:0] off);
        t_item it;
        it.op = op;
        it.offset = off;
        pending_items.push_back(it);
    endtask

    // random run: about one offset in four items, the rest ticks
    task automatic push_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) push_item(OP_OFFSET, rand_offset(cfg_thresh));
            else push_item(OP_TICK, 48'({$urandom(), $urandom()}));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = cdl_pkg::REG_ENABLE;
        i_cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.op = 1'b0;
        in_bus.offset = '0;
        out_bus.ready = 1'b0;
        stall_in = 0;
        stall_out = 0;
        idle_off = 0;
        done = 0;
        in_taken = 0;
        error_count = 0;
        quiet_cycles = 0;
        cfg_enable = 1'b1;
        cfg_thresh = cdl_pkg::THRESH_RST;
        cfg_prec = cdl_pkg::PREC_RST;
        cfg_phase = cdl_pkg::PHASE_RST;
        cfg_freq = cdl_pkg::FREQ_RST;
        cfg_track = cdl_pkg::TRACK_RST;
        cfg_comp = cdl_pkg::COMP_RST;
        cfg_factor = cdl_pkg::FACTOR_RST;
        drift_q = 0;
        comp_avg_q = 0;
        phase_err_q = 0;
        remainder_q = 0;
        elapsed_q = 0;
        first_q = 1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, extremes, step, first and timeless updates
        push_item(OP_TICK, '0);
        push_item(OP_OFFSET, 48'd1000);
        push_item(OP_OFFSET, 48'd2000);
        push_item(OP_TICK, 48'hffff_ffff_ffff);
        push_item(OP_OFFSET, -48'd5000000);
        push_item(OP_OFFSET, 48'h7fff_ffff_ffff);
        push_item(OP_OFFSET, 48'h8000_0000_0000);
        push_item(OP_OFFSET, 48'(cdl_pkg::THRESH_RST));
        push_item(OP_OFFSET, -48'(cdl_pkg::THRESH_RST));
        push_item(OP_OFFSET, 48'(cdl_pkg::THRESH_RST) + 1);
        push_item(OP_TICK, '0);
        push_item(OP_OFFSET, 48'd300000000);
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '0);
        push_item(OP_OFFSET, -48'd300000000);
        push_item(OP_TICK, '0);
        drain();

        // zero precision, zero phase and drift shifts, enormous threshold
        write_reg(cdl_pkg::REG_PREC, 47'd0);
        write_reg(cdl_pkg::REG_PHASE, 47'd0);
        write_reg(cdl_pkg::REG_FREQ, 47'd0);
        write_reg(cdl_pkg::REG_THRESH, {47{1'b1}});
        push_item(OP_OFFSET, 48'h7fff_ffff_ffff);
        push_item(OP_TICK, '0);
        push_item(OP_OFFSET, 48'h8000_0000_0000);
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '0);
        drain();

        // disabled: everything ignored
        write_reg(cdl_pkg::REG_ENABLE, 47'd0);
        push_item(OP_OFFSET, 48'd77);
        push_item(OP_TICK, '0);
        drain();
        write_reg(cdl_pkg::REG_ENABLE, 47'd1);

        // random phases across several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(cdl_pkg::REG_THRESH, cdl_pkg::THRESH_RST);
                    write_reg(cdl_pkg::REG_PREC, cdl_pkg::PREC_RST);
                    write_reg(cdl_pkg::REG_PHASE, cdl_pkg::PHASE_RST);
                    write_reg(cdl_pkg::REG_FREQ, cdl_pkg::FREQ_RST);
                end
                1: begin
                    write_reg(cdl_pkg::REG_PREC, 47'd5000);
                    write_reg(cdl_pkg::REG_TRACK, 47'd0);
                    write_reg(cdl_pkg::REG_COMP, 47'd0);
                    write_reg(cdl_pkg::REG_FACTOR, 47'd0);
                end
                2: begin
                    write_reg(cdl_pkg::REG_PREC, 47'h1fff);
                    write_reg(cdl_pkg::REG_TRACK, 47'd31);
                    write_reg(cdl_pkg::REG_COMP, 47'd31);
                    write_reg(cdl_pkg::REG_FACTOR, 47'd31);
                    write_reg(cdl_pkg::REG_PHASE, 47'd31);
                    write_reg(cdl_pkg::REG_FREQ, 47'd31);
                end
                3: begin
                    write_reg(cdl_pkg::REG_THRESH, 47'd0);
                    write_reg(cdl_pkg::REG_PREC, 47'd1);
                end
                4: begin
                    write_reg(cdl_pkg::REG_THRESH, {47{1'b1}});
                    write_reg(cdl_pkg::REG_PHASE, 47'd2);
                    write_reg(cdl_pkg::REG_FREQ, 47'd0);
                    write_reg(cdl_pkg::REG_COMP, 47'd20);
                    write_reg(cdl_pkg::REG_FACTOR, 47'd5);
                end
                5: begin
                    write_reg(cdl_pkg::REG_THRESH,
                              47'(64'($urandom_range(1000, 900000000))));
                    write_reg(cdl_pkg::REG_PREC, 47'($urandom_range(1, 5000)));
                    write_reg(cdl_pkg::REG_PHASE, 47'($urandom_range(0, 31)));
                    write_reg(cdl_pkg::REG_FREQ, 47'($urandom_range(0, 31)));
                    write_reg(cdl_pkg::REG_TRACK, 47'($urandom_range(0, 31)));
                    write_reg(cdl_pkg::REG_COMP, 47'($urandom_range(0, 31)));
                    write_reg(cdl_pkg::REG_FACTOR, 47'($urandom_range(0, 31)));
                end
                6: begin
                    write_reg(cdl_pkg::REG_ENABLE, 47'd1);
                    write_reg(cdl_pkg::REG_THRESH, cdl_pkg::THRESH_RST);
                    write_reg(cdl_pkg::REG_PREC, 47'd10);
                    write_reg(cdl_pkg::REG_PHASE, cdl_pkg::PHASE_RST);
                    write_reg(cdl_pkg::REG_FREQ, cdl_pkg::FREQ_RST);
                    write_reg(cdl_pkg::REG_TRACK, cdl_pkg::TRACK_RST);
                    write_reg(cdl_pkg::REG_COMP, cdl_pkg::COMP_RST);
                    write_reg(cdl_pkg::REG_FACTOR, cdl_pkg::FACTOR_RST);
                end
                default: idle_off = 1;   // closing stretch with no idling
            endcase
            push_random(100);
            if (ph == 2) begin
                // sender holds off until the block has delivered everything
                while (pending_items.size() != 0 || expected_results.size() != 0)
                    @(posedge i_clk);
                push_random(10);
            end
            drain();
        end

        done = 1;
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
